FILE: rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
package ffba_pkg;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_FREE    = 2'd1;
  localparam logic [1:0] FN_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_DOUBLE    = 3'd5;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic [31:0] RST_HEAP_BASE  = 32'd4096;
  localparam logic [31:0] RST_HEAP_LIMIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] bytes;
    logic        is_free;
  } ent_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_HIT,
    RES_NEW,
    RES_ADDR
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_FIND,
    S_FOUND,
    S_SCAN_FIT,
    S_APPEND,
    S_COMMIT,
    S_RELEASE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic       load;
    logic       scan_clr;
    logic       scan_run;
    logic       fit;
    logic       latch_k;
    logic       wr_hit_used;
    logic       wr_k_free;
    logic       append;
    logic       calc;
    logic       set_res;
    res_sel_t   res_sel;
    logic [2:0] st;
    logic       copy_set;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_zero;
    logic       addr_null;
    logic       hit;
    logic       done;
    logic       k_free;
    logic       fits_k;
    logic       full;
    logic       exhausted;
    logic       out_free;
  } sts_t;

endpackage

FILE: rtl/ffba_in_if.sv
// Request channel: operation, size and address words.
interface ffba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] req_size;
  logic [31:0] addr;

  modport source (output valid, func, req_size, addr, input ready);
  modport sink   (input valid, func, req_size, addr, output ready);
endinterface

FILE: rtl/ffba_out_if.sv
// Result channel: returned address, status and copy length words.
interface ffba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic [2:0]  status;
  logic [31:0] copy_bytes;

  modport source (output valid, result_addr, status, copy_bytes, input ready);
  modport sink   (input valid, result_addr, status, copy_bytes, output ready);
endinterface

FILE: rtl/ffba_ctrl.sv
// Controller state machine: sequences lookup, first-fit scan, append, release and reply.
module ffba_ctrl import ffba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func == FN_ALLOC || (sts.func == FN_REALLOC && sts.addr_null)) begin
          if (sts.size_zero) begin
            cmd.set_res = 1'b1;
            cmd.st      = ST_ZERO;
            state_nxt   = S_RESP;
          end else begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN_FIT;
          end
        end else if ((sts.func == FN_FREE || sts.func == FN_REALLOC) && !sts.addr_null) begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN_FIND;
        end else begin
          cmd.set_res = 1'b1;
          cmd.st      = ST_OK;
          state_nxt   = S_RESP;
        end
      end
      S_SCAN_FIND: begin
        if (sts.hit) begin
          cmd.latch_k = 1'b1;
          state_nxt   = S_FOUND;
        end else if (sts.done) begin
          cmd.set_res = 1'b1;
          cmd.st      = ST_UNKNOWN;
          state_nxt   = S_RESP;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_FOUND: begin
        if (sts.k_free) begin
          cmd.set_res = 1'b1;
          cmd.st      = ST_DOUBLE;
          state_nxt   = S_RESP;
        end else if (sts.func == FN_FREE) begin
          cmd.wr_k_free = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.st        = ST_OK;
          state_nxt     = S_RESP;
        end else if (sts.fits_k) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_ADDR;
          cmd.st      = ST_OK;
          state_nxt   = S_RESP;
        end else begin
          cmd.scan_clr = 1'b1;
          state_nxt    = S_SCAN_FIT;
        end
      end
      S_SCAN_FIT: begin
        cmd.fit = 1'b1;
        if (sts.hit) begin
          cmd.wr_hit_used = 1'b1;
          cmd.set_res     = 1'b1;
          cmd.res_sel     = RES_HIT;
          cmd.st          = ST_OK;
          state_nxt       = (sts.func == FN_REALLOC && !sts.addr_null) ? S_RELEASE : S_RESP;
        end else if (sts.done) begin
          state_nxt = S_APPEND;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.calc  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.set_res = 1'b1;
        if (sts.full) begin
          cmd.st    = ST_FULL;
          state_nxt = S_RESP;
        end else if (sts.exhausted) begin
          cmd.st    = ST_EXHAUSTED;
          state_nxt = S_RESP;
        end else begin
          cmd.append  = 1'b1;
          cmd.res_sel = RES_NEW;
          cmd.st      = ST_OK;
          state_nxt   = (sts.func == FN_REALLOC && !sts.addr_null) ? S_RELEASE : S_RESP;
        end
      end
      S_RELEASE: begin
        cmd.wr_k_free = 1'b1;
        cmd.copy_set  = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/ffba_dp.sv
// Datapath: block table memory, scan pointer, heap top, config and result registers.
module ffba_dp import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_addr,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_addr,
  output logic [2:0]  out_status,
  output logic [31:0] out_copy_bytes
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  ent_t mem [MAX_BLOCKS];

  logic [1:0]    func_r;
  logic [31:0]   size_r, addr_r;
  logic [CW-1:0] idx_r, count_r;
  logic [IW-1:0] chk_idx_r, k_idx_r;
  logic          rd_vld_r;
  ent_t          rd_ent_r, k_ent_r;
  logic [33:0]   end_r;
  logic [31:0]   top_r, limit_r;
  logic [31:0]   res_w_r, copy_w_r;
  logic [2:0]    st_w_r;
  logic          out_valid_r;
  logic [31:0]   out_res_r, out_copy_r;
  logic [2:0]    out_st_r;

  logic          issue, match, wr_en;
  logic [IW-1:0] wr_idx;
  ent_t          wr_ent;
  logic [32:0]   payload;
  logic [31:0]   res_nxt;

  assign payload = {1'b0, top_r} + 33'(HEADER_BYTES);
  assign issue   = cmd.scan_run && (idx_r < count_r);
  assign match   = cmd.fit ? (rd_ent_r.is_free && rd_ent_r.bytes >= size_r)
                           : (rd_ent_r.start == addr_r);

  always_comb begin
    sts.func      = func_r;
    sts.size_zero = (size_r == 32'd0);
    sts.addr_null = (addr_r == 32'd0);
    sts.hit       = rd_vld_r && match;
    sts.done      = !rd_vld_r && (idx_r >= count_r);
    sts.k_free    = k_ent_r.is_free;
    sts.fits_k    = (size_r <= k_ent_r.bytes);
    sts.full      = (count_r >= CW'(MAX_BLOCKS));
    sts.exhausted = (end_r > {2'b00, limit_r}) || (payload == 33'd0);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = chk_idx_r;
    wr_ent = rd_ent_r;
    if (cmd.wr_hit_used) begin
      wr_en          = 1'b1;
      wr_ent.is_free = 1'b0;
    end else if (cmd.wr_k_free) begin
      wr_en          = 1'b1;
      wr_idx         = k_idx_r;
      wr_ent         = k_ent_r;
      wr_ent.is_free = 1'b1;
    end else if (cmd.append) begin
      wr_en          = 1'b1;
      wr_idx         = count_r[IW-1:0];
      wr_ent.start   = payload[31:0];
      wr_ent.bytes   = size_r;
      wr_ent.is_free = 1'b0;
    end
  end

  always_comb begin
    case (cmd.res_sel)
      RES_HIT:  res_nxt = rd_ent_r.start;
      RES_NEW:  res_nxt = payload[31:0];
      RES_ADDR: res_nxt = addr_r;
      default:  res_nxt = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    if (issue) begin
      rd_ent_r <= mem[idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      size_r <= in_req_size;
      addr_r <= in_addr;
    end
    if (issue) begin
      chk_idx_r <= idx_r[IW-1:0];
    end
    if (cmd.latch_k) begin
      k_idx_r <= chk_idx_r;
      k_ent_r <= rd_ent_r;
    end
    if (cmd.calc) begin
      end_r <= {1'b0, payload} + {2'b00, size_r};
    end
    if (cmd.set_res) begin
      res_w_r  <= res_nxt;
      st_w_r   <= cmd.st;
      copy_w_r <= 32'd0;
    end else if (cmd.copy_set) begin
      copy_w_r <= k_ent_r.bytes;
    end
    if (cmd.out_load) begin
      out_res_r  <= res_w_r;
      out_st_r   <= st_w_r;
      out_copy_r <= copy_w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      top_r       <= RST_HEAP_BASE;
      limit_r     <= RST_HEAP_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_clr) begin
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        rd_vld_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CW'(1);
        end
      end
      if (cmd.append) begin
        count_r <= count_r + CW'(1);
        top_r   <= end_r[31:0];
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_HEAP_BASE: begin
            if (count_r == '0) begin
              top_r <= cfg_data;
            end
          end
          REG_HEAP_LIMIT: begin
            limit_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_res_r;
  assign out_status      = out_st_r;
  assign out_copy_bytes  = out_copy_r;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: controller plus datapath.
//
//   channel  dir  handshake        word
//   in_ch    in   valid/ready      func, req_size, addr
//   out_ch   out  valid/ready      result_addr, status, copy_bytes
//   cfg_*    in   cfg_we only      cfg_idx (0 heap_base, 1 heap_limit), cfg_data
//
// One request at a time. The block table is read one entry per cycle through its
// registered read port; with N live blocks an appending allocate scans all N entries
// before it appends, and a moving reallocate of the last block scans the table twice.
// The next request is taken in the cycle after the result is loaded.
// Synchronous active-low reset empties the table, sets the heap top to RST_HEAP_BASE and the limit to RST_HEAP_LIMIT.
// A new request is taken while a result still waits in the output register; the
// next result is held back until that one is taken.
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data,
  ffba_in_if.sink     in_ch,
  ffba_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffba_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_func         (in_ch.func),
    .in_req_size     (in_ch.req_size),
    .in_addr         (in_ch.addr),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_result_addr (out_ch.result_addr),
    .out_status      (out_ch.status),
    .out_copy_bytes  (out_ch.copy_bytes)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the first-fit block allocator: directed table, then random traffic.
module tb;
  import ffba_pkg::*;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int LONG_HOLD    = 500;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] req_size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [2:0]  status;
    logic [31:0] copy_bytes;
  } reply_t;

  typedef struct {
    req_t        rq;
    logic        typed;
    reply_t      want;
    logic        cfg_on;
    logic        cfg_reg;
    logic [31:0] cfg_val;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [31:0] cfg_data;

  ffba_in_if  in_ch();
  ffba_out_if out_ch();

  first_fit_block_allocator #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  always #5 clk = ~clk;

  // heap image
  logic [31:0] blk_addr [MAX_BLOCKS];
  logic [31:0] blk_len  [MAX_BLOCKS];
  logic        blk_open [MAX_BLOCKS];
  int          n_blocks = 0;
  logic [31:0] brk       = RST_HEAP_BASE;
  logic [31:0] limit_reg = RST_HEAP_LIMIT;

  reply_t replies_due[$];
  row_t   rows[$];
  int     mismatches = 0;
  int     replies_checked = 0;
  int     cycle_count = 0;
  int     gap_odds = 0;
  int     stall_odds = 0;
  bit     held_long = 1'b0;

  function automatic int locate_block(input logic [31:0] a);
    int i;
    for (i = 0; i < n_blocks; i++)
      if (blk_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic logic [2:0] carve_block(input logic [31:0] size, output logic [31:0] where);
    int i;
    logic [33:0] payload;
    logic [33:0] stop;
    where = '0;
    if (size == 0) return ST_ZERO;
    for (i = 0; i < n_blocks; i++) begin
      if (blk_open[i] && blk_len[i] >= size) begin
        blk_open[i] = 1'b0;
        where = blk_addr[i];
        return ST_OK;
      end
    end
    if (n_blocks >= MAX_BLOCKS) return ST_FULL;
    payload = {2'b0, brk} + 34'(HEADER_BYTES);
    stop = payload + {2'b0, size};
    if (stop > {2'b0, limit_reg} || payload == 0) return ST_EXHAUSTED;
    blk_addr[n_blocks] = payload[31:0];
    blk_len[n_blocks]  = size;
    blk_open[n_blocks] = 1'b0;
    n_blocks++;
    brk = stop[31:0];
    where = payload[31:0];
    return ST_OK;
  endfunction

  function automatic reply_t heap_step(input req_t rq);
    reply_t rep;
    int k;
    rep = '0;
    case (rq.func)
      FN_ALLOC: rep.status = carve_block(rq.req_size, rep.result_addr);
      FN_FREE: begin
        if (rq.addr != 0) begin
          k = locate_block(rq.addr);
          if (k < 0) rep.status = ST_UNKNOWN;
          else if (blk_open[k]) rep.status = ST_DOUBLE;
          else blk_open[k] = 1'b1;
        end
      end
      FN_REALLOC: begin
        if (rq.addr == 0) begin
          rep.status = carve_block(rq.req_size, rep.result_addr);
        end else begin
          k = locate_block(rq.addr);
          if (k < 0) begin
            rep.status = ST_UNKNOWN;
          end else if (blk_open[k]) begin
            rep.status = ST_DOUBLE;
          end else if (rq.req_size <= blk_len[k]) begin
            rep.result_addr = rq.addr;
          end else begin
            rep.status = carve_block(rq.req_size, rep.result_addr);
            if (rep.status == ST_OK) begin
              rep.copy_bytes = blk_len[k];
              blk_open[k] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_request(input req_t rq, input logic typed, input reply_t want);
    reply_t rep;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.func     = rq.func;
    in_ch.req_size = rq.req_size;
    in_ch.addr     = rq.addr;
    do @(posedge clk); while (!in_ch.ready);
    rep = heap_step(rq);
    replies_due.push_back(typed ? want : rep);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    in_ch.valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    if (idx == REG_HEAP_BASE) begin
      if (n_blocks == 0) brk = val;
    end else begin
      limit_reg = val;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stalls plus one long hold-off to back up the request side
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_long && replies_checked >= 150) begin
        held_long = 1'b1;
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : watch
    reply_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      replies_checked++;
      if (replies_due.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = replies_due.pop_front();
        if (out_ch.result_addr !== want.result_addr)
          report_mismatch($sformatf("result_addr %h, want %h",
                                    out_ch.result_addr, want.result_addr));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.copy_bytes !== want.copy_bytes)
          report_mismatch($sformatf("copy_bytes %0d, want %0d",
                                    out_ch.copy_bytes, want.copy_bytes));
      end
    end
  end

  initial begin
    req_t rq;
    int   pick;
    int   k;
    int   p;
    int   j;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_HEAP_BASE;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.func     = FN_ALLOC;
    in_ch.req_size = '0;
    in_ch.addr     = '0;

    // empty table with the break at the very top
    rows.push_back('{'{FN_ALLOC, 32'd0, 32'd0}, 1, '{32'd0, ST_ZERO, 32'd0},
                     1, REG_HEAP_BASE, 32'hFFFF_FFFF});
    rows.push_back('{'{FN_ALLOC, 32'd1, 32'd0}, 1, '{32'd0, ST_EXHAUSTED, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_FREE, 32'd0, 32'd0}, 1, '{32'd0, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_FREE, 32'd0, 32'hFFFF_FFFF}, 1, '{32'd0, ST_UNKNOWN, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd0, 32'd0}, 1, '{32'd0, ST_ZERO, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd5, 32'h1234}, 1, '{32'd0, ST_UNKNOWN, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1, '{32'd0, ST_OK, 32'd0},
                     0, 0, 0});
    // break restarts at 1: payloads land at 25, 57, ...
    rows.push_back('{'{FN_ALLOC, 32'd8, 32'd0}, 1, '{32'd25, ST_OK, 32'd0},
                     1, REG_HEAP_BASE, 32'd1});
    rows.push_back('{'{FN_ALLOC, 32'hFFFF_FFFF, 32'd0}, 1, '{32'd0, ST_EXHAUSTED, 32'd0},
                     0, 0, 0});
    rows.push_back('{'{FN_ALLOC, 32'd100, 32'd0}, 1, '{32'd57, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_FREE, 32'd0, 32'd25}, 1, '{32'd0, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_FREE, 32'd0, 32'd25}, 1, '{32'd0, ST_DOUBLE, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_FREE, 32'd0, 32'd26}, 1, '{32'd0, ST_UNKNOWN, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_ALLOC, 32'd4, 32'd0}, 1, '{32'd25, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd8, 32'd25}, 1, '{32'd25, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd0, 32'd25}, 1, '{32'd25, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd9, 32'd25}, 1, '{32'd181, ST_OK, 32'd8}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd3, 32'd25}, 1, '{32'd0, ST_DOUBLE, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_REALLOC, 32'd100, 32'd57}, 1, '{32'd57, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_ALLOC, 32'd8, 32'd0}, 1, '{32'd25, ST_OK, 32'd0}, 0, 0, 0});
    rows.push_back('{'{FN_ALLOC, 32'd1, 32'd0}, 0, '0, 0, 0, 0});
    // tight limit: failed growth, failed moving realloc, exact fit at the limit
    rows.push_back('{'{FN_ALLOC, 32'd200, 32'd0}, 0, '0, 1, REG_HEAP_LIMIT, 32'd300});
    rows.push_back('{'{FN_REALLOC, 32'd500, 32'd57}, 0, '0, 0, 0, 0});
    rows.push_back('{'{FN_ALLOC, 32'd61, 32'd0}, 0, '0, 0, 0, 0});
    rows.push_back('{'{FN_ALLOC, 32'd1, 32'd0}, 0, '0, 0, 0, 0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    gap_odds   = 6;
    stall_odds = 5;
    foreach (rows[r]) begin
      if (rows[r].cfg_on) write_reg(rows[r].cfg_reg, rows[r].cfg_val);
      send_request(rows[r].rq, rows[r].typed, rows[r].want);
    end

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(REG_HEAP_LIMIT, brk + $urandom_range(500, 3000));
          gap_odds = 4; stall_odds = 4;
        end
        1: begin
          write_reg(REG_HEAP_BASE, $urandom);
          write_reg(REG_HEAP_LIMIT, 32'd1);
          gap_odds = 8; stall_odds = 3;
        end
        2: begin
          write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
          gap_odds = 0; stall_odds = 0;
        end
        3: begin
          write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
          write_reg(REG_HEAP_LIMIT, $urandom);
          gap_odds = 3; stall_odds = 6;
        end
        4: begin
          write_reg(REG_HEAP_BASE, 32'd1);
          write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
          gap_odds = 5; stall_odds = 2;
        end
        default: begin
          gap_odds = 0; stall_odds = 0;
        end
      endcase
      for (j = 0; j < 300; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) rq.func = FN_ALLOC;
        else if (pick < 70) rq.func = FN_FREE;
        else if (pick < 96) rq.func = FN_REALLOC;
        else rq.func = FN_UNUSED;
        k = (n_blocks == 0) ? -1 : int'($urandom_range(0, n_blocks - 1));
        pick = $urandom_range(0, 19);
        if (pick < 2) rq.addr = '0;
        else if (pick < 4 || k < 0) rq.addr = $urandom;
        else if (pick == 4) rq.addr = blk_addr[k] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        else rq.addr = blk_addr[k];
        pick = $urandom_range(0, 19);
        case (pick)
          0: rq.req_size = '0;
          1: rq.req_size = $urandom;
          2: rq.req_size = 32'hFFFF_FFFF;
          3, 4: rq.req_size = (k < 0) ? 32'd1 : blk_len[k] + $urandom_range(0, 1);
          default: rq.req_size = $urandom_range(1, 64);
        endcase
        send_request(rq, 1'b0, '0);
      end
    end

    in_ch.valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2 * MAX_BLOCKS + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ffba_pkg.sv
rtl/ffba_in_if.sv
rtl/ffba_out_if.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator.sv
dv/tb.sv
